@@ hdl/fatlb_pkg.sv @@
// package for the fully associative translation buffer
// holds sizes, status codes, the controller state type and the command and status structs; no dependencies
package fatlb_pkg;
  localparam int ENTRIES_DEF = 32;
  localparam int VADDR_BITS_DEF = 48;
  localparam int PADDR_BITS_DEF = 40;
  localparam int PAGE_BITS_DEF = 14;
  localparam int MIN_PAGE_BITS_DEF = 12;
  localparam int VA_W = 48;
  localparam int PA_W = 40;
  localparam int OUT_ADDR_BITS = 40;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_INVALID = 3'd1,
    ST_ALL_FIXED = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_MISS = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PICK, S_WRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic bad_param;
  } stat_t;
endpackage

@@ hdl/fatlb_ctrl.sv @@
// controller state machine for the translation buffer
// depends on fatlb_pkg
module fatlb_ctrl import fatlb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_fire,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        state_next = (st.is_insert && !st.bad_param) ? S_PICK : S_OUT;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ hdl/fatlb_datapath.sv @@
// tag compare, slot selection and entry storage of the translation buffer
// depends on fatlb_pkg
module fatlb_datapath import fatlb_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int VADDR_BITS = VADDR_BITS_DEF,
  parameter int PADDR_BITS = PADDR_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int MIN_PAGE_BITS = MIN_PAGE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic                     func,
  input  logic [VA_W-1:0]          virt_address,
  input  logic [PA_W-1:0]          phys_address,
  input  logic                     entry_valid,
  input  logic                     entry_fixed,
  input  logic                     entry_present,
  output stat_t                    st,
  output status_t                  status,
  output logic [OUT_ADDR_BITS-1:0] result_address
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VB = (VADDR_BITS < VA_W) ? VADDR_BITS : VA_W;
  localparam int TAG_W = VB - PAGE_BITS;
  localparam int PB = (PADDR_BITS < PA_W) ? PADDR_BITS : PA_W;
  localparam int FR_W = PA_W - PAGE_BITS;

  logic [TAG_W-1:0] tags [ENTRIES];
  logic [FR_W-1:0]  frames [ENTRIES];
  logic [ENTRIES-1:0] valid, pinned, present;
  logic [IW-1:0] victim;

  // operands held for the whole transaction
  logic             op_trans, op_v, op_f, op_p;
  logic [TAG_W-1:0] vpn;
  logic [FR_W-1:0]  frm;
  logic [PAGE_BITS-1:0] off;
  logic             bad;

  logic [ENTRIES-1:0] hit, free_r;
  logic [IW-1:0]      slot;

  logic [PA_W-1:0] pa_m;
  always_comb begin
    pa_m = phys_address;
    pa_m[MIN_PAGE_BITS-1:0] = '0;
  end

  always_comb
    for (int i = 0; i < ENTRIES; i++)
      hit[i] = valid[i] && (tags[i] == vpn);

  assign st.is_insert = !op_trans;
  assign st.bad_param = bad;

  // lowest free slot, else first unpinned at or after the victim pointer
  logic           sel_found, sel_free;
  logic [IW-1:0]  sel_slot, k;
  int             vj;
  always_comb begin
    sel_found = 1'b0;
    sel_free = 1'b0;
    sel_slot = '0;
    k = '0;
    vj = 0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (free_r[i]) begin
        sel_free = 1'b1;
        sel_slot = IW'(i);
      end
    if (!sel_free)
      for (int j = ENTRIES - 1; j >= 0; j--) begin
        vj = int'(victim) + j;
        if (vj >= ENTRIES) vj = vj - ENTRIES;
        k = IW'(vj);
        if (!pinned[k]) begin
          sel_found = 1'b1;
          sel_slot = k;
        end
      end
    else sel_found = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      pinned <= '0;
      victim <= '0;
    end else begin
      if (cmd.scan && !op_trans && !bad) begin
        valid <= valid & ~hit;
        pinned <= pinned & ~hit;
      end
      if (cmd.pick && !sel_free && sel_found)
        victim <= (sel_slot == IW'(ENTRIES - 1)) ? '0 : sel_slot + 1'b1;
      if (cmd.write && status == ST_OK) begin
        valid[slot] <= op_v;
        pinned[slot] <= op_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && status == ST_OK) begin
      tags[slot] <= vpn;
      frames[slot] <= frm;
      present[slot] <= op_p;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_trans <= func;
      op_v <= entry_valid;
      op_f <= entry_fixed;
      op_p <= entry_present;
      vpn <= virt_address[VB-1:PAGE_BITS];
      off <= virt_address[PAGE_BITS-1:0];
      frm <= pa_m[PA_W-1:PAGE_BITS];
      bad <= !func && ((virt_address[PAGE_BITS-1:0] != '0)
             || (pa_m[PAGE_BITS-1:0] != '0)
             || ((PB < PA_W) && ((pa_m >> PB) != '0)));
      status <= ST_OK;
      result_address <= '0;
    end
    if (cmd.scan) begin
      free_r <= ~valid | hit;
      if (op_trans) begin
        status <= ST_MISS;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (hit[i]) begin
            status <= present[i] ? ST_OK : ST_NOT_PRESENT;
            result_address <= present[i]
              ? OUT_ADDR_BITS'({frames[i], off}) : '0;
          end
      end else if (bad) status <= ST_INVALID;
    end
    if (cmd.pick) begin
      slot <= sel_slot;
      if (!sel_found) status <= ST_ALL_FIXED;
    end
  end
endmodule

@@ hdl/fully_associative_tlb.sv @@
// fully associative translation buffer, top level
// one transaction at a time: after acceptance the controller runs the scan step, then for an insert
// with valid parameters the pick and write steps, and then presents the result; a translate or an
// insert with bad parameters skips pick and write; reset clears valid and pinned bits and the victim pointer
// depends on fatlb_pkg, fatlb_ctrl, fatlb_datapath
module fully_associative_tlb import fatlb_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int VADDR_BITS = VADDR_BITS_DEF,
  parameter int PADDR_BITS = PADDR_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int MIN_PAGE_BITS = MIN_PAGE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // virt_address, phys_address, entry_valid,
                                 // entry_fixed, entry_present, zero fill
  input  logic         s_tuser,  // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [47:0]  m_tdata   // status, result_address, zero fill
);
  cmd_t    cmd;
  stat_t   st;
  logic    busy;
  status_t status;
  logic [OUT_ADDR_BITS-1:0] raddr;

  assign s_tready = !busy;

  fatlb_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(s_tvalid && s_tready),
    .out_fire(m_tvalid && m_tready),
    .st, .cmd, .busy, .out_valid(m_tvalid)
  );

  fatlb_datapath #(
    .ENTRIES(ENTRIES), .VADDR_BITS(VADDR_BITS), .PADDR_BITS(PADDR_BITS),
    .PAGE_BITS(PAGE_BITS), .MIN_PAGE_BITS(MIN_PAGE_BITS)
  ) u_dp (
    .clk, .rst, .cmd,
    .func(s_tuser),
    .virt_address(s_tdata[47:0]),
    .phys_address(s_tdata[87:48]),
    .entry_valid(s_tdata[88]),
    .entry_fixed(s_tdata[89]),
    .entry_present(s_tdata[90]),
    .st, .status, .result_address(raddr)
  );

  assign m_tdata = {5'd0, raddr, status};
endmodule

@@ dv/tb_fully_associative_tlb.sv @@
// testbench for the fully associative translation buffer
// self-checking: a behavioral tlb model predicts each result; depends on fatlb_pkg and the rtl
module tb_fully_associative_tlb;
  import fatlb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 32;
  localparam int PGB = 14;
  localparam int MINPG = 12;
  localparam int LIMIT = 20000;
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_XLATE = 1'b1;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [95:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [47:0] m_tdata;

  fully_associative_tlb dut (.*);

  typedef struct packed {
    status_t st;
    logic [39:0] addr;
  } xlat_res_t;

  // predicted translation buffer state
  logic [33:0] vpn_tab[NSLOT];
  logic [25:0] pfn_tab[NSLOT];
  logic [NSLOT-1:0] live, pin, pres;
  int vptr;

  xlat_res_t expq[$];
  int errors = 0;
  int idle_cyc = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_recv = 0;
  bit done = 0;
  logic [47:0] pages[16];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic xlat_res_t tlb_predict(logic fn, logic [47:0] va, logic [39:0] pa_in,
                                            logic v, logic f, logic p);
    xlat_res_t r;
    logic [39:0] pa;
    logic [33:0] vpn;
    int cand;
    r.st = ST_OK;
    r.addr = '0;
    vpn = va[47:PGB];
    cand = -1;
    if (fn == FN_XLATE) begin
      r.st = ST_MISS;
      for (int i = 0; i < NSLOT; i++) begin
        if (live[i] && vpn_tab[i] == vpn) begin
          if (!pres[i]) r.st = ST_NOT_PRESENT;
          else begin
            r.st = ST_OK;
            r.addr = {pfn_tab[i], va[PGB-1:0]};
          end
          break;
        end
      end
      return r;
    end
    pa = pa_in & ~40'((1 << MINPG) - 1);
    if (va[PGB-1:0] != '0 || pa[PGB-1:0] != '0) begin
      r.st = ST_INVALID;
      return r;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (!live[i]) begin
        if (cand < 0) cand = i;
      end else if (vpn_tab[i] == vpn) begin
        live[i] = 0;
        pin[i] = 0;
        if (cand < 0) cand = i;
      end
    end
    if (cand < 0) begin
      for (int k = 0; k < NSLOT; k++) begin
        if (!pin[(vptr + k) % NSLOT]) begin
          cand = (vptr + k) % NSLOT;
          break;
        end
      end
      if (cand < 0) begin
        r.st = ST_ALL_FIXED;
        return r;
      end
      vptr = (cand + 1) % NSLOT;
    end
    vpn_tab[cand] = vpn;
    pfn_tab[cand] = pa[39:PGB];
    live[cand] = v;
    pin[cand] = f;
    pres[cand] = p;
    return r;
  endfunction

  task automatic send_op(logic fn, logic [47:0] va, logic [39:0] pa, logic v, logic f,
                         logic p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {53'b0, p, f, v, pa, va};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expq.push_back(tlb_predict(fn, va, pa, v, f, p));
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expq.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [47:0] pick_page();
    return pages[$urandom_range(15)];
  endfunction

  task automatic test_directed();
    send_op(FN_XLATE, 48'hFFFF_FFFF_FFFF, '1, 1'b1, 1'b1, 1'b1);
    send_op(FN_INSERT, 48'h0000_0000_0001, 40'h0, 1'b1, 1'b0, 1'b1);
    send_op(FN_INSERT, 48'h0, 40'h0000_0000_2000, 1'b1, 1'b0, 1'b1);
    send_op(FN_INSERT, 48'h0, 40'h0000_0000_0FFF, 1'b1, 1'b0, 1'b1);
    send_op(FN_INSERT, 48'hFFFF_FFFF_C000, 40'hFF_FFFF_CFFF, 1'b1, 1'b0, 1'b1);
    send_op(FN_XLATE, 48'hFFFF_FFFF_FFFF, 40'h0, 1'b0, 1'b0, 1'b0);
    send_op(FN_XLATE, 48'h0, 40'h0, 1'b0, 1'b0, 1'b0);
    send_op(FN_INSERT, 48'h4000, 40'h8000, 1'b1, 1'b1, 1'b0);
    send_op(FN_XLATE, 48'h5ABC, 40'h0, 1'b0, 1'b0, 1'b0);
    send_op(FN_INSERT, 48'h8000, 40'hC000, 1'b0, 1'b0, 1'b1);
    send_op(FN_XLATE, 48'h8001, 40'h0, 1'b0, 1'b0, 1'b0);
    send_op(FN_INSERT, 48'h4000, 40'h1_0000, 1'b1, 1'b0, 1'b1);
    send_op(FN_XLATE, 48'h7FFF, 40'h0, 1'b0, 1'b0, 1'b0);
    // fill every slot pinned, then insert must fail
    for (int i = 0; i < NSLOT; i++)
      send_op(FN_INSERT, 48'(i + 100) << PGB, 40'(i) << PGB, 1'b1, 1'b1, 1'b1);
    send_op(FN_INSERT, 48'h3_0000_0000, 40'h4000, 1'b1, 1'b0, 1'b1);
    // same pages again unpinned so later inserts can replace them
    for (int i = 0; i < NSLOT; i++)
      send_op(FN_INSERT, 48'(i + 100) << PGB, 40'(i) << PGB, 1'b1, 1'b0, 1'b1);
    drain();
  endtask

  // replacement with a mix of pinned and unpinned entries
  task automatic test_replace();
    for (int i = 0; i < 200; i++)
      send_op(FN_INSERT, 48'($urandom_range(63)) << PGB, 40'($urandom) << PGB, 1'b1,
              $urandom_range(9) == 0, 1'($urandom_range(1)));
    drain();
  endtask

  task automatic test_random(int n);
    logic [47:0] va;
    logic [39:0] pa;
    for (int i = 0; i < n; i++) begin
      va = pick_page() | ($urandom_range(1) ? 48'({$urandom} & 16'h3FFF) : 48'h0);
      pa = 40'({$urandom, $urandom}) & (($urandom_range(4) == 0) ? '1 : 40'hFF_FFFF_CFFF);
      case ($urandom_range(9))
        0: va = 48'({$urandom, $urandom});
        1: va[PGB-1:0] = '0;
        default: ;
      endcase
      send_op($urandom_range(9) < 5 ? FN_XLATE : FN_INSERT, va, pa,
              $urandom_range(7) != 0, $urandom_range(7) == 0, $urandom_range(5) != 0);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_recv = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      for (int i = 0; i < 20; i++) send_op(FN_XLATE, pick_page(), '0, 1'b0, 1'b0, 1'b0);
    join
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expq.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", m_tdata);
      end else begin
        xlat_res_t e;
        e = expq.pop_front();
        if (m_tdata[2:0] !== e.st || m_tdata[42:3] !== e.addr) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d addr=%h got st=%0d addr=%h",
                     e.st, e.addr, m_tdata[2:0], m_tdata[42:3]);
        end
      end
    end
    m_tready <= !hold_recv && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || done) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tuser = 0;
    s_tdata = '0;
    m_tready = 0;
    live = '0;
    pin = '0;
    pres = '0;
    vptr = 0;
    for (int i = 0; i < 16; i++) pages[i] = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_C000;
    pages[0] = '0;
    pages[1] = 48'hFFFF_FFFF_C000;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle_pct = 17;
    recv_idle_pct = 54;
    test_directed();
    test_replace();
    test_random(350);
    send_idle_pct = 54;
    recv_idle_pct = 17;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(480);
    done = 1;
    if (errors == 0 && expq.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
